/* sv/yuv_plane_format_converter_core_macros.svh */
// Assertion macros used by the converter top level.
`ifndef YUV_PLANE_FORMAT_CONVERTER_CORE_MACROS_SVH
`define YUV_PLANE_FORMAT_CONVERTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define YUVPFC_ASSERT_NOW(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("yuvpfc assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define YUVPFC_ASSERT_NEXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("yuvpfc assertion failed");
`else
`define YUVPFC_ASSERT_NOW(label, clock, rstn, ante, cons)
`define YUVPFC_ASSERT_NEXT(label, clock, rstn, ante, cons)
`endif
`endif

/* sv/yuvpfc_pkg.sv */
// Shared types, codes and helper function of the plane format converter.
package yuvpfc_pkg;

	localparam int LINE_MAX_DEF   = 4096;
	localparam int PIXEL_BITS_DEF = 16;

	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 3;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_PLANE_MODE     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WIDE_SAMPLES   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HORIZ_RATIO    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_VERT_RATIO     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_FILE_WIDTH     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_FILE_BIT_DEPTH = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_SHIFT    = 3'd6;

	// Plane modes.
	localparam logic [1:0] MODE_CONVERT = 2'd0;
	localparam logic [1:0] MODE_FILL    = 2'd1;

	// Two-bit signed ratio codes.
	localparam logic [1:0] RATIO_KEEP_EVEN = 2'b01;
	localparam logic [1:0] RATIO_EXPAND    = 2'b11;

	// Input commands.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	// Scaling controls handed from the top level to the scaler.
	typedef struct packed {
		logic [4:0] depth;   // effective file bit depth, 1..16
		logic [4:0] shift;   // two's complement depth difference
	} scale_cfg_t;

	// File bit depth clamped to 1..16.
	function automatic logic [4:0] eff_depth(input logic [4:0] d);
		logic [4:0] r;
		r = d;
		if (d == 5'd0) begin
			r = 5'd1;
		end else if (d > 5'd16) begin
			r = 5'd16;
		end
		return r;
	endfunction

endpackage

/* sv/yuvpfc_line_store.sv */
// Line store: one line of raw samples, one port, registered read data.
module yuvpfc_line_store #(
	parameter int DEPTH = yuvpfc_pkg::LINE_MAX_DEF,
	parameter int AW    = $clog2(yuvpfc_pkg::LINE_MAX_DEF)
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [15:0]   wdata,
	output logic [15:0]   rdata
);
	import yuvpfc_pkg::*;

	logic [15:0] mem [DEPTH];

	// Read returns the old contents; a sample writes and never needs its own read.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

/* sv/yuvpfc_scale.sv */
// Depth scaler: pass-through at zero shift, left shift with truncation, or rounded right shift with clipping.
module yuvpfc_scale #(
	parameter int PIXEL_BITS = yuvpfc_pkg::PIXEL_BITS_DEF
) (
	input  yuvpfc_pkg::scale_cfg_t cfg,
	input  logic [15:0]            value,
	output logic [15:0]            pixel
);
	import yuvpfc_pkg::*;

	localparam logic [15:0] PMASK = 16'((32'd1 << PIXEL_BITS) - 32'd1);

	logic signed [4:0] sh;
	logic [4:0]        rs;
	logic [31:0]       shl;
	logic [16:0]       rsum;
	logic [16:0]       rres;
	logic signed [5:0] e;
	logic [15:0]       maxv;

	always_comb begin
		sh   = $signed(cfg.shift);
		rs   = 5'(5'd0 - cfg.shift);
		shl  = 32'(value) << cfg.shift[3:0];
		rsum = 17'(value) + (17'd1 << (rs - 5'd1));
		rres = rsum >> rs;
		e    = $signed({1'b0, cfg.depth}) + $signed({cfg.shift[4], cfg.shift});
		if (e <= 6'sd0) begin
			maxv = 16'd0;
		end else if (e >= $signed(6'(PIXEL_BITS))) begin
			maxv = PMASK;
		end else begin
			maxv = 16'((17'd1 << e[4:0]) - 17'd1);
		end
		if (sh > 5'sd0) begin
			pixel = shl[15:0] & PMASK;
		end else if (sh < 5'sd0) begin
			pixel = (rres > {1'b0, maxv}) ? maxv : rres[15:0];
		end else begin
			pixel = value;
		end
	end

endmodule

/* sv/yuv_plane_format_converter_core.sv */
// Top level of the plane format converter: raw file samples in, scaled pixels out.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-----------------------------------------
//   s_       | in        | s_tvalid/s_tready  | tdata: low_byte, high_byte; tuser: command
//   m_       | out       | m_tvalid/m_tready  | tdata: pixel; tlast: row_end; tuser: last
//   cfg_     | in        | cfg_we (no wait)   | cfg_index, cfg_data
//
// An item with zero or one pixel leaves stage 1 at once, so a new transfer can be taken
// every cycle while the output is not stalled; an item that doubles a pixel holds the output
// register for two transfers, so in doubling mode the output side sets the input pace.
// A pixel passes through stage 1 and the output register, scaled on its way to the output.
// Reset clears control state and the configuration registers; data and the line store are not cleared.
// A stalled output backs up through the stage register to s_tready.
module yuv_plane_format_converter_core #(
	parameter int LINE_MAX   = yuvpfc_pkg::LINE_MAX_DEF,
	parameter int PIXEL_BITS = yuvpfc_pkg::PIXEL_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [15:0]                         s_tdata,    // [7:0] low_byte, [15:8] high_byte
	input  logic                                s_tuser,    // [0] command
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [15:0]                         m_tdata,    // [15:0] pixel
	output logic                                m_tlast,    // row_end
	output logic                                m_tuser,    // [0] last
	input  logic                                cfg_we,
	input  logic [yuvpfc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [yuvpfc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import yuvpfc_pkg::*;
	`include "yuv_plane_format_converter_core_macros.svh"

	// Column and address width, and the width that holds the line length itself.
	localparam int CW = $clog2(LINE_MAX);
	localparam int WW = $clog2(LINE_MAX + 1);

	// Configuration registers.
	logic [1:0]  plane_mode_q;
	logic        wide_samples_q;
	logic [1:0]  horiz_ratio_q;
	logic [1:0]  vert_ratio_q;
	logic [12:0] file_width_q;
	logic [4:0]  file_bit_depth_q;
	logic [4:0]  depth_shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_mode_q     <= MODE_CONVERT;
			wide_samples_q   <= 1'b0;
			horiz_ratio_q    <= 2'b00;
			vert_ratio_q     <= 2'b00;
			file_width_q     <= 13'd1;
			file_bit_depth_q <= 5'd8;
			depth_shift_q    <= 5'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PLANE_MODE:     plane_mode_q     <= cfg_data[1:0];
				REG_WIDE_SAMPLES:   wide_samples_q   <= cfg_data[0];
				REG_HORIZ_RATIO:    horiz_ratio_q    <= cfg_data[1:0];
				REG_VERT_RATIO:     vert_ratio_q     <= cfg_data[1:0];
				REG_FILE_WIDTH:     file_width_q     <= cfg_data[12:0];
				REG_FILE_BIT_DEPTH: file_bit_depth_q <= cfg_data[4:0];
				REG_DEPTH_SHIFT:    depth_shift_q    <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Line position state.
	logic [CW-1:0] column_q;
	logic          row_parity_q;

	// Stage 1: the decided item, waiting for the scaler and output register.
	logic        valid_s1;
	logic        has_s1;        // the item produces at least one pixel
	logic        dbl_s1;        // the item produces two equal pixels
	logic        re_s1;         // the final pixel closes a destination row
	logic        use_store_s1;  // the value comes from the line store read
	logic [15:0] raw_s1;
	logic [15:0] store_rdata;

	// Output register.
	logic        out_valid_q;
	logic [15:0] pix_q;
	logic        two_q;
	logic        beat_q;
	logic        re_q;

	// Decision logic at the input side.
	logic          s_acc;
	logic          m_acc;
	logic [WW-1:0] w_eff;
	logic [WW-1:0] kept;
	logic [CW-1:0] col_eff;
	logic [WW-1:0] c1;
	logic [WW:0]   c2;
	logic          wrapped;
	logic          is_conv;
	logic          is_fill;
	logic          is_tick;
	logic          do_h;
	logic          emit;
	logic          store_we;
	logic [15:0]   raw_in;
	logic [15:0]   fill_val;
	logic          has_d;
	logic          dbl_d;
	logic          re_d;

	always_comb begin
		if (file_width_q == 13'd0) begin
			w_eff = WW'(1);
		end else if (32'(file_width_q) > 32'(LINE_MAX)) begin
			w_eff = WW'(LINE_MAX);
		end else begin
			w_eff = WW'(file_width_q);
		end
		kept = w_eff & ~WW'(1);

		// A width written no larger than the current column restarts the line.
		col_eff = (WW'(column_q) >= w_eff) ? '0 : column_q;
		c1      = WW'(col_eff) + WW'(1);
		c2      = (WW+1)'(col_eff) + (WW+1)'(2);
		wrapped = (c1 >= w_eff);

		is_conv = (plane_mode_q == MODE_CONVERT);
		is_fill = (plane_mode_q == MODE_FILL);
		is_tick = (s_tuser == CMD_TICK);

		// The horizontal rule runs (and the column moves) for fill ticks, replay ticks
		// when the line store is in use, and every sample in convert mode.
		do_h = (is_fill && is_tick)
			|| (is_conv && is_tick && vert_ratio_q == RATIO_EXPAND)
			|| (is_conv && !is_tick);
		// Odd file lines are silent when vertical decimation is on.
		emit = do_h && !(is_conv && !is_tick && vert_ratio_q == RATIO_KEEP_EVEN
			&& row_parity_q);
		store_we = is_conv && !is_tick;

		raw_in   = wide_samples_q ? s_tdata : {8'd0, s_tdata[7:0]};
		fill_val = 16'd1 << (eff_depth(file_bit_depth_q) - 5'd1);

		unique case (horiz_ratio_q)
			RATIO_KEEP_EVEN: begin
				has_d = emit && !col_eff[0] && (c1 < w_eff);
				dbl_d = 1'b0;
				re_d  = (c2 == (WW+1)'(kept));
			end
			RATIO_EXPAND: begin
				has_d = emit;
				dbl_d = 1'b1;
				re_d  = (c1 == w_eff);
			end
			default: begin
				has_d = emit;
				dbl_d = 1'b0;
				re_d  = (c1 == w_eff);
			end
		endcase
	end

	// Handshakes. Stage 1 moves on when it has nothing to show or the output register
	// frees up this cycle.
	logic out_final;
	logic out_free;
	logic s1_adv;

	assign out_final = !two_q || beat_q;
	assign m_acc     = out_valid_q && m_tready;
	assign out_free  = !out_valid_q || (m_tready && out_final);
	assign s1_adv    = valid_s1 && (!has_s1 || out_free);
	assign s_tready  = !valid_s1 || s1_adv;
	assign s_acc     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= '0;
			row_parity_q <= 1'b0;
		end else if (s_acc) begin
			column_q <= (do_h && !wrapped) ? CW'(c1) : (do_h ? '0 : col_eff);
			if (store_we && wrapped) begin
				row_parity_q <= !row_parity_q;
			end
		end
	end

	yuvpfc_line_store #(
		.DEPTH (LINE_MAX),
		.AW    (CW)
	) u_line_store (
		.clk   (clk),
		.en    (s_acc),
		.we    (store_we),
		.addr  (col_eff),
		.wdata (raw_in),
		.rdata (store_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			has_s1       <= has_d;
			dbl_s1       <= dbl_d;
			re_s1        <= re_d;
			use_store_s1 <= is_conv && is_tick;
			raw_s1       <= is_fill ? fill_val : raw_in;
		end
	end

	// Scaling between stage 1 and the output register.
	scale_cfg_t  scfg;
	logic [15:0] scaled;

	assign scfg.depth = eff_depth(file_bit_depth_q);
	assign scfg.shift = depth_shift_q;

	yuvpfc_scale #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_scale (
		.cfg   (scfg),
		.value (use_store_s1 ? store_rdata : raw_s1),
		.pixel (scaled)
	);

	logic out_load;
	assign out_load = s1_adv && has_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			two_q       <= 1'b0;
			beat_q      <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			two_q       <= dbl_s1;
			beat_q      <= 1'b0;
		end else if (m_acc) begin
			if (out_final) begin
				out_valid_q <= 1'b0;
			end else begin
				beat_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pix_q <= scaled;
			re_q  <= re_s1;
		end
	end

	// The first of two doubled pixels never closes a row and is never the final one.
	assign m_tvalid = out_valid_q;
	assign m_tdata  = pix_q;
	assign m_tlast  = out_final && re_q;
	assign m_tuser  = out_final;

	// A second beat only exists for a doubled pixel.
	`YUVPFC_ASSERT_NOW(a_beat_needs_two, clk, arst_n, out_valid_q && beat_q, two_q)
	// Taking the first of two doubled pixels leaves the second one on show.
	`YUVPFC_ASSERT_NEXT(a_second_follows, clk, arst_n,
		out_valid_q && two_q && !beat_q && m_tready, out_valid_q && beat_q)
	// The input side only stalls while stage 1 holds an item it cannot pass on.
	`YUVPFC_ASSERT_NOW(a_stall_reason, clk, arst_n, !s_tready, valid_s1 && has_s1 && out_valid_q)

endmodule

/* sim/yuv_plane_format_converter_core_test.sv */
// Self-checking testbench for the plane format converter core.
module yuv_plane_format_converter_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import yuvpfc_pkg::*;

	localparam int STORE_DEPTH = LINE_MAX_DEF;
	localparam int ITEM_TARGET = 1300;
	// Cycles for an item that makes no pixel to clear the two-stage pipeline.
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_CYCLES = 300;

	// Codes that the package does not name.
	localparam logic [1:0] MODE_DROP      = 2'd2;
	localparam logic [1:0] MODE_SPARE     = 2'd3;
	localparam logic [1:0] RATIO_PASS     = 2'b00;
	localparam logic [1:0] RATIO_ALT_PASS = 2'b10;

	typedef struct {
		logic [15:0] pixel;
		logic        row_end;
		logic        last;
	} pixel_t;

	// Tracks the converter's registers, line store and line position, and turns each
	// accepted input transfer into the pixels the block must produce for it.
	class pixel_predictor;
		logic [1:0]        mode_r = MODE_CONVERT;
		logic              wide_r = 1'b0;
		logic [1:0]        horiz_r = RATIO_PASS;
		logic [1:0]        vert_r = RATIO_PASS;
		logic [12:0]       width_r = 13'd1;
		logic [4:0]        depth_r = 5'd8;
		logic signed [4:0] shift_r = 5'sd0;
		logic [15:0]       line_mem [STORE_DEPTH];
		bit                line_valid [STORE_DEPTH];
		int unsigned       col = 0;
		bit                odd_row = 1'b0;
		pixel_t            pending_pixels [$];
		int                mismatches = 0;

		function void write_reg(input logic [2:0] idx, input logic [12:0] val);
			case (idx)
				REG_PLANE_MODE:     mode_r = val[1:0];
				REG_WIDE_SAMPLES:   wide_r = val[0];
				REG_HORIZ_RATIO:    horiz_r = val[1:0];
				REG_VERT_RATIO:     vert_r = val[1:0];
				REG_FILE_WIDTH:     width_r = val;
				REG_FILE_BIT_DEPTH: depth_r = val[4:0];
				REG_DEPTH_SHIFT:    shift_r = val[4:0];
				default: ;
			endcase
		endfunction

		function int unsigned line_len();
			if (width_r == 13'd0) begin
				return 1;
			end
			return (width_r > STORE_DEPTH) ? STORE_DEPTH : int'(width_r);
		endfunction

		function int unsigned file_depth();
			if (depth_r == 5'd0) begin
				return 1;
			end
			return (depth_r > 5'd16) ? 16 : int'(depth_r);
		endfunction

		function int unsigned next_column();
			return (col >= line_len()) ? 0 : col;
		endfunction

		// A replay of a store entry that was never written must not be sent.
		function bit can_replay();
			if (mode_r != MODE_CONVERT || vert_r != RATIO_EXPAND) begin
				return 1'b1;
			end
			return line_valid[next_column() % STORE_DEPTH];
		endfunction

		// Left shift truncated to 16 bits, or rounded right shift clipped to the
		// largest value of the internal depth.
		function logic [15:0] scale(input logic [15:0] v);
			int          sh;
			int          s;
			int          e;
			logic [31:0] v32;
			logic [31:0] maxv;
			logic [31:0] r;
			sh = shift_r;
			v32 = {16'h0000, v};
			if (sh > 0) begin
				return 16'(v32 << sh);
			end
			if (sh == 0) begin
				return v;
			end
			s = -sh;
			e = int'(file_depth()) + sh;
			if (e <= 0) begin
				maxv = 32'd0;
			end else if (e >= 16) begin
				maxv = 32'h0000_FFFF;
			end else begin
				maxv = (32'd1 << e) - 32'd1;
			end
			r = (v32 + (32'd1 << (s - 1))) >> s;
			return (r > maxv) ? maxv[15:0] : r[15:0];
		endfunction

		function void push(input logic [15:0] pix, input bit re, input bit lst);
			pixel_t p;
			p.pixel = pix;
			p.row_end = re;
			p.last = lst;
			pending_pixels.push_back(p);
		endfunction

		// Horizontal rule at the current column, then the column moves on.
		function bit advance(input logic [15:0] raw, input bit emit);
			int unsigned w;
			int unsigned c;
			int unsigned kept;
			logic [15:0] pix;
			bit          wrapped;
			w = line_len();
			c = col;
			if (emit) begin
				pix = scale(raw);
				if (horiz_r == RATIO_KEEP_EVEN) begin
					kept = 2 * (w / 2);
					if ((c % 2) == 0 && c + 1 < w) begin
						push(pix, c + 2 == kept, 1'b1);
					end
				end else if (horiz_r == RATIO_EXPAND) begin
					push(pix, 1'b0, 1'b0);
					push(pix, c + 1 == w, 1'b1);
				end else begin
					push(pix, c + 1 == w, 1'b1);
				end
			end
			wrapped = (c + 1 >= w);
			col = wrapped ? 0 : c + 1;
			return wrapped;
		endfunction

		// Notes one accepted input transfer. Returns 0 when the block ignores it.
		function bit accept_item(input logic cmd, input logic [7:0] lo, input logic [7:0] hi);
			int unsigned a;
			logic [15:0] raw;
			bit          wrapped;
			// The column is pulled back to zero on any input, even an ignored one.
			if (col >= line_len()) begin
				col = 0;
			end
			if (mode_r == MODE_FILL) begin
				if (cmd != CMD_TICK) begin
					return 1'b0;
				end
				wrapped = advance(16'(32'd1 << (file_depth() - 1)), 1'b1);
				return 1'b1;
			end
			if (mode_r != MODE_CONVERT) begin
				return 1'b0;
			end
			a = col % STORE_DEPTH;
			if (cmd == CMD_TICK) begin
				if (vert_r != RATIO_EXPAND) begin
					return 1'b0;
				end
				wrapped = advance(line_mem[a], 1'b1);
				return 1'b1;
			end
			raw = wide_r ? {hi, lo} : {8'h00, lo};
			line_mem[a] = raw;
			line_valid[a] = 1'b1;
			wrapped = advance(raw, !(vert_r == RATIO_KEEP_EVEN && odd_row));
			if (wrapped) begin
				odd_row = !odd_row;
			end
			return 1'b1;
		endfunction

		function void check_pixel(input logic [15:0] pix, input logic re, input logic lst);
			pixel_t e;
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel transfer: pixel %h row_end %b last %b", pix, re, lst);
				mismatches++;
				return;
			end
			e = pending_pixels.pop_front();
			if (pix !== e.pixel) begin
				$error("pixel: expected %h, got %h", e.pixel, pix);
				mismatches++;
			end
			if (re !== e.row_end) begin
				$error("row_end: expected %b, got %b", e.row_end, re);
				mismatches++;
			end
			if (lst !== e.last) begin
				$error("last: expected %b, got %b", e.last, lst);
				mismatches++;
			end
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [15:0]            s_tdata = 16'h0000;
	logic                   s_tuser = CMD_SAMPLE;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [15:0]            m_tdata;
	logic                   m_tlast;
	logic                   m_tuser;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_PLANE_MODE;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	pixel_predictor pred = new;

	// Idle percentages of each side; the receiver hold is a separate override.
	int src_idle = 0;
	int sink_idle = 0;
	logic sink_hold = 1'b0;
	int items_used = 0;

	yuv_plane_format_converter_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver: checks every pixel transfer against the oldest expectation, then
	// picks the ready level for the next cycle. Values are taken as they stood
	// just before the edge, since all drives here are nonblocking.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				pred.check_pixel(m_tdata, m_tlast, m_tuser);
			end
			m_tready <= !sink_hold && ($urandom_range(99) >= sink_idle);
		end
	end

	// Holds the output off for a fixed number of cycles so that the block backs up
	// and stops taking input transfers.
	task automatic hold_sink(input int cycles);
		sink_hold <= 1'b1;
		repeat (cycles) @(posedge clk);
		sink_hold <= 1'b0;
	endtask

	// Offers one item and returns at the edge where it is taken. The valid line is
	// left high so that back-to-back items never drop it within a time step.
	task automatic send_item(input logic cmd, input logic [7:0] lo, input logic [7:0] hi);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {hi, lo};
		s_tuser <= cmd;
		do begin
			@(posedge clk);
		end while (!s_tready);
		if (pred.accept_item(cmd, lo, hi)) begin
			items_used++;
		end
	endtask

	// Stops the input and waits until every expected pixel has arrived, plus the
	// pipeline depth for trailing items that make no pixel.
	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (pred.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [12:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		pred.write_reg(idx, val);
		@(posedge clk);
	endtask

	// Writes all seven registers on consecutive cycles; only called while idle.
	task automatic configure(input logic [12:0] mode, input logic [12:0] wide,
			input logic [12:0] horiz, input logic [12:0] vert, input logic [12:0] width,
			input logic [12:0] depth, input logic [12:0] shift);
		put_reg(REG_PLANE_MODE, mode);
		put_reg(REG_WIDE_SAMPLES, wide);
		put_reg(REG_HORIZ_RATIO, horiz);
		put_reg(REG_VERT_RATIO, vert);
		put_reg(REG_FILE_WIDTH, width);
		put_reg(REG_FILE_BIT_DEPTH, depth);
		put_reg(REG_DEPTH_SHIFT, shift);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [12:0] shift_code(input int s);
		return 13'(s & 31);
	endfunction

	// Short directed pass over the extremes, every mode and the corner cases.
	task automatic directed();
		// Wide pass-through at full depth; a tick is ignored outside line replay.
		configure(MODE_CONVERT, 1, RATIO_PASS, RATIO_PASS, 3, 16, 0);
		send_item(CMD_SAMPLE, 8'h00, 8'h00);
		send_item(CMD_SAMPLE, 8'hFF, 8'hFF);
		send_item(CMD_TICK, 8'h5A, 8'hA5);
		send_item(CMD_SAMPLE, 8'h12, 8'h80);
		quiesce();
		// Keep-even with a zero width acts as width one and yields nothing.
		configure(MODE_CONVERT, 0, RATIO_KEEP_EVEN, RATIO_KEEP_EVEN, 0, 8, 0);
		send_item(CMD_SAMPLE, 8'hAA, 8'h55);
		send_item(CMD_SAMPLE, 8'h55, 8'hAA);
		quiesce();
		// Doubling with a stored line replayed by ticks and a rounded right shift.
		configure(MODE_CONVERT, 0, RATIO_EXPAND, RATIO_EXPAND, 3, 8, shift_code(-2));
		send_item(CMD_SAMPLE, 8'hFF, 8'h00);
		send_item(CMD_SAMPLE, 8'h01, 8'hFF);
		send_item(CMD_SAMPLE, 8'h80, 8'h01);
		send_item(CMD_TICK, 8'h00, 8'h00);
		send_item(CMD_TICK, 8'hFF, 8'hFF);
		send_item(CMD_TICK, 8'h3C, 8'hC3);
		quiesce();
		// Ratio code minus two passes; oversize width and zero depth are clamped.
		configure(MODE_CONVERT, 1, RATIO_ALT_PASS, RATIO_ALT_PASS, 13'h1FFF, 0, 8);
		send_item(CMD_SAMPLE, 8'hFF, 8'hFF);
		send_item(CMD_SAMPLE, 8'h01, 8'h80);
		quiesce();
		// Fill: ticks give mid grey, samples are ignored; depth above 16 is clamped.
		configure(MODE_FILL, 0, RATIO_EXPAND, RATIO_PASS, 2, 17, shift_code(-8));
		send_item(CMD_TICK, 8'h00, 8'h00);
		send_item(CMD_SAMPLE, 8'hFF, 8'hFF);
		send_item(CMD_TICK, 8'h00, 8'h00);
		quiesce();
		// Fill at depth one with the largest left shift.
		configure(MODE_FILL, 1, RATIO_KEEP_EVEN, RATIO_KEEP_EVEN, 2, 1, 15);
		send_item(CMD_TICK, 8'h00, 8'h00);
		send_item(CMD_TICK, 8'hFF, 8'hFF);
		quiesce();
		// Drop mode and the spare mode code consume everything silently.
		configure(MODE_DROP, 0, RATIO_PASS, RATIO_PASS, 4, 8, 0);
		send_item(CMD_SAMPLE, 8'h11, 8'h22);
		send_item(CMD_TICK, 8'h33, 8'h44);
		quiesce();
		configure(MODE_SPARE, 1, RATIO_EXPAND, RATIO_EXPAND, 4, 8, 0);
		send_item(CMD_SAMPLE, 8'h55, 8'h66);
		send_item(CMD_TICK, 8'h77, 8'h88);
		quiesce();
	endtask

	// Random register setting, mostly short lines and in-range depths and shifts.
	task automatic random_setup(output int len);
		int          pick;
		logic [12:0] mode;
		logic [12:0] width;
		logic [12:0] depth;
		logic [12:0] shift;
		pick = $urandom_range(19);
		if (pick < 13) begin
			mode = MODE_CONVERT;
		end else if (pick < 18) begin
			mode = MODE_FILL;
		end else if (pick == 18) begin
			mode = MODE_DROP;
		end else begin
			mode = MODE_SPARE;
		end
		len = $urandom_range(90, 40);
		case ($urandom_range(15))
			0: begin
				width = 13'd0;
			end
			1: begin
				width = 13'(4096 + $urandom_range(4095));
				len = $urandom_range(40, 20);
			end
			2: begin
				width = 13'($urandom_range(8191));
				len = $urandom_range(40, 20);
			end
			default: begin
				width = 13'($urandom_range(12, 1));
			end
		endcase
		if ($urandom_range(7) == 0) begin
			depth = 13'($urandom_range(31));
		end else begin
			depth = 13'($urandom_range(16, 1));
		end
		if ($urandom_range(7) == 0) begin
			shift = 13'($urandom_range(31));
		end else begin
			shift = shift_code(int'($urandom_range(16)) - 8);
		end
		if (mode == MODE_DROP || mode == MODE_SPARE) begin
			len = 10;
		end
		configure(mode, 13'($urandom_range(1)), 13'($urandom_range(3)),
			13'($urandom_range(3)), width, depth, shift);
	endtask

	// Random items shaped by the current mode. In line-replay mode whole lines are
	// either sample lines or tick lines, with a little noise; a tick that would
	// read a store entry never written is turned into a sample.
	task automatic run_segment(input int len);
		int   k;
		bit   replay;
		logic cmd;
		logic [7:0] lo;
		logic [7:0] hi;
		replay = 1'b0;
		for (k = 0; k < len; k++) begin
			lo = 8'($urandom);
			hi = 8'($urandom);
			if (pred.mode_r == MODE_CONVERT && pred.vert_r == RATIO_EXPAND) begin
				if (pred.next_column() == 0) begin
					replay = ($urandom_range(1) == 1);
				end
				cmd = replay ? CMD_TICK : CMD_SAMPLE;
				if ($urandom_range(9) == 0) begin
					cmd = (cmd == CMD_TICK) ? CMD_SAMPLE : CMD_TICK;
				end
				if (cmd == CMD_TICK && !pred.can_replay()) begin
					cmd = CMD_SAMPLE;
				end
			end else if (pred.mode_r == MODE_FILL) begin
				cmd = ($urandom_range(4) != 0) ? CMD_TICK : CMD_SAMPLE;
			end else begin
				cmd = ($urandom_range(9) == 0) ? CMD_TICK : CMD_SAMPLE;
			end
			send_item(cmd, lo, hi);
		end
	endtask

	initial begin
		int  len;
		bit  stalled;
		stalled = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle = 24;
		sink_idle = 73;
		directed();

		while (items_used < ITEM_TARGET) begin
			// Idle phases: first the sender idles lightly and the receiver heavily,
			// then the reverse, and in the last third neither side idles.
			if (items_used >= 2 * ITEM_TARGET / 3) begin
				src_idle = 0;
				sink_idle = 0;
			end else if (items_used >= ITEM_TARGET / 3) begin
				src_idle = 73;
				sink_idle = 24;
			end
			if (src_idle == 0 && !stalled) begin
				// The sender keeps offering doubled pixels while the receiver is held
				// off, so the block fills up and must stall its input.
				stalled = 1'b1;
				configure(MODE_CONVERT, 1, RATIO_EXPAND, RATIO_PASS, 7, 10, 3);
				fork
					hold_sink(STALL_CYCLES);
				join_none
				run_segment(80);
			end else begin
				random_setup(len);
				run_segment(len);
			end
			// Every segment ends with the sender paused until all pixels are in.
			quiesce();
		end

		if (pred.mismatches == 0 && pred.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run of this stimulus.
	initial begin
		#10ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
